// File: design/etbas_pkg.sv
// Shared types and constants for the expert token block-align sorter.
// Holds field widths, operation, status and register codes and parameter defaults.
// No dependencies.
`default_nettype none

package etbas_pkg;

   // Field widths of the request, response and register ports.
   localparam int OP_W      = 3;
   localparam int ID_W      = 8;
   localparam int INDEX_W   = 14;
   localparam int ANS_W     = 15;
   localparam int STAT_W    = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 9;

   // Block size register and its usable range.
   localparam int BLOCK_W   = 9;
   localparam int BLOCK_MAX = 256;

   // Width of the block start product (index times block size plus one block).
   localparam int PROD_W = INDEX_W + BLOCK_W;

   // Parameter defaults.
   localparam int DEF_MAX_EXPERTS = 256;
   localparam int DEF_MAX_TOKENS  = 4096;
   localparam int DEF_MAX_SLOTS   = 16384;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_COUNT       = 3'd0;
   localparam logic [OP_W-1:0] OP_FINALIZE    = 3'd1;
   localparam logic [OP_W-1:0] OP_PLACE       = 3'd2;
   localparam logic [OP_W-1:0] OP_READ_SLOT   = 3'd3;
   localparam logic [OP_W-1:0] OP_READ_BLOCK  = 3'd4;
   localparam logic [OP_W-1:0] OP_READ_OFFSET = 3'd5;

   // Status codes.
   localparam logic [STAT_W-1:0] STS_OK  = 2'd0;
   localparam logic [STAT_W-1:0] STS_ARG = 2'd1;
   localparam logic [STAT_W-1:0] STS_OVF = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_EXPERT_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SIZE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAD_ENABLE   = 2'd2;

   // Register reset values.
   localparam logic [CSR_W-1:0]   RST_EXPERT_COUNT = 9'd256;
   localparam logic [BLOCK_W-1:0] RST_BLOCK_SIZE   = 9'd64;

endpackage

`default_nettype wire

// File: design/etbas_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Parameterized in width and depth; no dependencies.
`default_nettype none

module etbas_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: design/etbas_round.sv
// Bit-serial unit that rounds a token count up to a multiple of the block size.
// Uses etbas_pkg for the block size width; one remainder bit per cycle.
`default_nettype none

module etbas_round #(
   parameter int TOKEN_W = 13,
   parameter int ROUND_W = 13
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [TOKEN_W-1:0]           dividend,
   input  logic [etbas_pkg::BLOCK_W-1:0] divisor,
   output logic                         done,
   output logic [ROUND_W-1:0]           rounded
);
   import etbas_pkg::*;

   localparam int CNT_W = $clog2(TOKEN_W + 1);

   logic               run_ff, run_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [TOKEN_W-1:0] dvd_ff, dvd_in;
   logic [TOKEN_W-1:0] src_ff, src_in;
   logic [BLOCK_W-1:0] rem_ff, rem_in;
   logic [BLOCK_W-1:0] div_ff, div_in;
   logic [BLOCK_W:0]   trial;

   assign trial = {rem_ff, dvd_ff[TOKEN_W-1]};
   assign done  = run_ff && (cnt_ff == '0);

   always_comb begin
      run_in = run_ff;
      cnt_in = cnt_ff;
      dvd_in = dvd_ff;
      src_in = src_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = CNT_W'(TOKEN_W);
         dvd_in = dividend;
         src_in = dividend;
         rem_in = '0;
         div_in = divisor;
      end else if (run_ff) begin
         if (cnt_ff == '0) begin
            run_in = 1'b0;
         end else begin
            // Restoring step: the remainder stays below the divisor.
            if (trial >= {1'b0, div_ff}) begin
               rem_in = BLOCK_W'(trial - {1'b0, div_ff});
            end else begin
               rem_in = BLOCK_W'(trial);
            end
            dvd_in = dvd_ff << 1;
            cnt_in = cnt_ff - CNT_W'(1);
         end
      end
   end

   always_comb begin
      if (rem_ff == '0) begin
         rounded = ROUND_W'(src_ff);
      end else begin
         rounded = ROUND_W'(src_ff) + ROUND_W'(div_ff) - ROUND_W'(rem_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      src_ff <= src_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

endmodule

`default_nettype wire

// File: design/expert_token_block_align_sort.sv
// Count, place, slot read and offset read pass through their own working state; a rejected
// item is answered from idle. Finalize walks the count memory twice through the serial
// rounding unit (once on slot overflow), then writes the padded slots in turn when padding is on.
// A block owner read checks the block, then makes one offset memory read per latched expert.
// One item at a time; the response strobe cannot be held off. Reset is synchronous and
// needs no clearing pass: expert counts carry per-entry valid bits that reset clears.
`default_nettype none

module expert_token_block_align_sort #(
   parameter int MAX_EXPERTS = etbas_pkg::DEF_MAX_EXPERTS,
   parameter int MAX_TOKENS  = etbas_pkg::DEF_MAX_TOKENS,
   parameter int MAX_SLOTS   = etbas_pkg::DEF_MAX_SLOTS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [etbas_pkg::OP_W-1:0]      req_operation,
   input  logic [etbas_pkg::ID_W-1:0]      req_expert_id,
   input  logic [etbas_pkg::INDEX_W-1:0]   req_index,
   output logic                            rsp_valid,
   output logic [etbas_pkg::ANS_W-1:0]     rsp_answer,
   output logic [etbas_pkg::STAT_W-1:0]    rsp_status,
   input  logic                            csr_write,
   input  logic [etbas_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [etbas_pkg::CSR_W-1:0]     csr_data
);
   import etbas_pkg::*;

   // Derived widths.
   localparam int EW  = $clog2(MAX_EXPERTS + 1);                 // expert count
   localparam int XW  = (MAX_EXPERTS > 1) ? $clog2(MAX_EXPERTS) : 1; // expert address
   localparam int OAW = $clog2(MAX_EXPERTS + 1);                 // offset address
   localparam int TW  = $clog2(MAX_TOKENS + 1);                  // token count
   localparam int RW  = $clog2(MAX_TOKENS + BLOCK_MAX);          // rounded count
   localparam int AW  = $clog2(MAX_TOKENS + MAX_EXPERTS * (BLOCK_MAX - 1) + 1);
   localparam int SW  = $clog2(MAX_SLOTS + 1);                   // slot count
   localparam int SAW = $clog2(MAX_SLOTS);                       // slot address
   localparam int DW  = (SW > TW) ? SW : TW;                     // slot contents

   // Sequencer states.
   localparam int STW = 4;
   localparam logic [STW-1:0] S_IDLE     = 4'd0;
   localparam logic [STW-1:0] S_CNT_WR   = 4'd1;
   localparam logic [STW-1:0] S_FIN_RD   = 4'd2;
   localparam logic [STW-1:0] S_FIN_KICK = 4'd3;
   localparam logic [STW-1:0] S_FIN_DIV  = 4'd4;
   localparam logic [STW-1:0] S_FIN_END  = 4'd5;
   localparam logic [STW-1:0] S_FILL     = 4'd6;
   localparam logic [STW-1:0] S_PL_WR    = 4'd7;
   localparam logic [STW-1:0] S_RD_SLOT  = 4'd8;
   localparam logic [STW-1:0] S_RD_OFF   = 4'd9;
   localparam logic [STW-1:0] S_BK_CHK   = 4'd10;
   localparam logic [STW-1:0] S_BK_RD    = 4'd11;
   localparam logic [STW-1:0] S_BK_CMP   = 4'd12;

   // Configuration registers and their clamped values.
   logic [CSR_W-1:0]   cfg_ec_ff, cfg_ec_in;
   logic [BLOCK_W-1:0] cfg_bs_ff, cfg_bs_in;
   logic               cfg_pad_ff, cfg_pad_in;
   logic [EW-1:0]      ec_used;
   logic [BLOCK_W-1:0] bs_used;

   // Control state.
   logic [STW-1:0]         state_ff, state_in;
   logic [MAX_EXPERTS-1:0] vld_ff, vld_in;
   logic [TW-1:0]          tc_ff, tc_in;
   logic [SW-1:0]          pc_ff, pc_in;
   logic [SW-1:0]          total_ff, total_in;
   logic [EW-1:0]          le_ff, le_in;
   logic [BLOCK_W-1:0]     lb_ff, lb_in;
   logic                   fin_ff, fin_in;
   logic                   have_off_ff, have_off_in;
   logic                   pass_ff, pass_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Working registers.
   logic [ID_W-1:0]   id_ff, id_in;
   logic [EW-1:0]     e_ff, e_in;
   logic [AW-1:0]     acc_ff, acc_in;
   logic [SW-1:0]     s_ff, s_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [EW-1:0]     owner_ff, owner_in;
   logic [ANS_W-1:0]  rsp_answer_ff, rsp_answer_in;
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;

   // Memory ports.
   logic            cnt_we;
   logic [XW-1:0]   cnt_waddr, cnt_raddr;
   logic [TW-1:0]   cnt_wdata, cnt_rdata;
   logic            off_we;
   logic [OAW-1:0]  off_waddr, off_raddr;
   logic [SW-1:0]   off_wdata, off_rdata;
   logic            fil_we;
   logic [XW-1:0]   fil_waddr, fil_raddr;
   logic [SW-1:0]   fil_wdata, fil_rdata;
   logic            slot_we;
   logic [SAW-1:0]  slot_waddr, slot_raddr;
   logic [DW-1:0]   slot_wdata, slot_rdata;

   // Rounding unit.
   logic          div_start;
   logic [TW-1:0] div_dividend;
   logic          div_done;
   logic [RW-1:0] div_rounded;

   logic [XW-1:0] e_addr;
   logic [XW-1:0] id_addr;

   assign e_addr  = e_ff[XW-1:0];
   assign id_addr = XW'(id_ff);

   // The register values are clamped into their usable range.
   always_comb begin
      if (cfg_ec_ff == '0) begin
         ec_used = EW'(1);
      end else if (cfg_ec_ff > MAX_EXPERTS) begin
         ec_used = EW'(MAX_EXPERTS);
      end else begin
         ec_used = EW'(cfg_ec_ff);
      end
      if (cfg_bs_ff == '0) begin
         bs_used = BLOCK_W'(1);
      end else if (cfg_bs_ff > BLOCK_MAX) begin
         bs_used = BLOCK_W'(BLOCK_MAX);
      end else begin
         bs_used = cfg_bs_ff;
      end
   end

   // Register writes; indexes beyond the list are ignored.
   always_comb begin
      cfg_ec_in  = cfg_ec_ff;
      cfg_bs_in  = cfg_bs_ff;
      cfg_pad_in = cfg_pad_ff;
      if (csr_write) begin
         priority if (csr_index == CSR_EXPERT_COUNT) begin
            cfg_ec_in = csr_data;
         end else if (csr_index == CSR_BLOCK_SIZE) begin
            cfg_bs_in = BLOCK_W'(csr_data);
         end else if (csr_index == CSR_PAD_ENABLE) begin
            cfg_pad_in = csr_data[0];
         end else begin
            // An index past the last register selects nothing.
         end
      end
   end

   // Read addresses are presented in the cycle an item is accepted, so the data
   // is ready in the following state.
   always_comb begin
      cnt_raddr  = (state_ff == S_IDLE) ? XW'(req_expert_id) : e_addr;
      fil_raddr  = XW'(req_expert_id);
      slot_raddr = SAW'(req_index);
      if (state_ff == S_IDLE) begin
         if (req_operation == OP_PLACE) begin
            off_raddr = OAW'(req_expert_id) + OAW'(1);
         end else begin
            off_raddr = OAW'(req_index);
         end
      end else begin
         off_raddr = OAW'(e_ff);
      end
   end

   always_comb begin
      state_in      = state_ff;
      vld_in        = vld_ff;
      tc_in         = tc_ff;
      pc_in         = pc_ff;
      total_in      = total_ff;
      le_in         = le_ff;
      lb_in         = lb_ff;
      fin_in        = fin_ff;
      have_off_in   = have_off_ff;
      pass_in       = pass_ff;
      id_in         = id_ff;
      e_in          = e_ff;
      acc_in        = acc_ff;
      s_in          = s_ff;
      prod_in       = prod_ff;
      owner_in      = owner_ff;
      rsp_valid_in  = 1'b0;
      rsp_answer_in = '0;
      rsp_status_in = STS_OK;

      cnt_we       = 1'b0;
      cnt_waddr    = id_addr;
      cnt_wdata    = '0;
      off_we       = 1'b0;
      off_waddr    = OAW'(e_ff);
      off_wdata    = SW'(acc_ff);
      fil_we       = 1'b0;
      fil_waddr    = e_addr;
      fil_wdata    = SW'(acc_ff);
      slot_we      = 1'b0;
      slot_waddr   = SAW'(s_ff);
      slot_wdata   = DW'(tc_ff);
      div_start    = 1'b0;
      div_dividend = vld_ff[e_addr] ? cnt_rdata : '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               id_in = req_expert_id;
               unique case (req_operation)
                  OP_COUNT: begin
                     // A count after a finalize opens a new batch.
                     if (fin_ff) begin
                        vld_in = '0;
                        tc_in  = '0;
                        pc_in  = '0;
                        fin_in = 1'b0;
                     end
                     if (req_expert_id >= ec_used) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STS_ARG;
                     end else if (!fin_ff && (tc_ff >= MAX_TOKENS)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STS_OVF;
                     end else begin
                        state_in = S_CNT_WR;
                     end
                  end
                  OP_FINALIZE: begin
                     e_in     = '0;
                     acc_in   = '0;
                     pass_in  = 1'b0;
                     state_in = S_FIN_RD;
                  end
                  OP_PLACE: begin
                     if (!fin_ff || (req_expert_id >= ec_used) ||
                         (req_expert_id >= le_ff)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STS_ARG;
                     end else begin
                        state_in = S_PL_WR;
                     end
                  end
                  OP_READ_SLOT: begin
                     if (req_index >= total_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STS_ARG;
                     end else begin
                        state_in = S_RD_SLOT;
                     end
                  end
                  OP_READ_BLOCK: begin
                     prod_in  = PROD_W'(req_index) * PROD_W'(lb_ff);
                     state_in = S_BK_CHK;
                  end
                  OP_READ_OFFSET: begin
                     if (req_index > le_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STS_ARG;
                     end else if (!have_off_ff) begin
                        // Offsets read as zero until the first finalize.
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = S_RD_OFF;
                     end
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STS_ARG;
                  end
               endcase
            end
         end
         S_CNT_WR: begin
            cnt_we          = 1'b1;
            cnt_waddr       = id_addr;
            cnt_wdata       = (vld_ff[id_addr] ? cnt_rdata : '0) + TW'(1);
            vld_in[id_addr] = 1'b1;
            tc_in           = tc_ff + TW'(1);
            rsp_valid_in    = 1'b1;
            state_in        = S_IDLE;
         end
         S_FIN_RD: begin
            state_in = S_FIN_KICK;
         end
         S_FIN_KICK: begin
            div_start = 1'b1;
            state_in  = S_FIN_DIV;
         end
         S_FIN_DIV: begin
            if (div_done) begin
               // The second walk stores each expert's start before adding its size.
               if (pass_ff) begin
                  off_we    = 1'b1;
                  off_waddr = OAW'(e_ff);
                  off_wdata = SW'(acc_ff);
                  fil_we    = 1'b1;
                  fil_waddr = e_addr;
                  fil_wdata = SW'(acc_ff);
               end
               acc_in = acc_ff + AW'(div_rounded);
               e_in   = e_ff + EW'(1);
               if ((e_ff + EW'(1)) == ec_used) begin
                  state_in = S_FIN_END;
               end else begin
                  state_in = S_FIN_RD;
               end
            end
         end
         S_FIN_END: begin
            if (!pass_ff) begin
               if (acc_ff > MAX_SLOTS) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STS_OVF;
                  state_in      = S_IDLE;
               end else begin
                  pass_in  = 1'b1;
                  acc_in   = '0;
                  e_in     = '0;
                  state_in = S_FIN_RD;
               end
            end else begin
               off_we    = 1'b1;
               off_waddr = OAW'(ec_used);
               off_wdata = SW'(acc_ff);
               total_in  = SW'(acc_ff);
               s_in      = '0;
               state_in  = S_FILL;
            end
         end
         S_FILL: begin
            if (cfg_pad_ff && (s_ff < total_ff)) begin
               slot_we    = 1'b1;
               slot_waddr = SAW'(s_ff);
               slot_wdata = DW'(tc_ff);
               s_in       = s_ff + SW'(1);
            end else begin
               le_in         = ec_used;
               lb_in         = bs_used;
               pc_in         = '0;
               fin_in        = 1'b1;
               have_off_in   = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_answer_in = ANS_W'(total_ff);
               state_in      = S_IDLE;
            end
         end
         S_PL_WR: begin
            if ((fil_rdata >= off_rdata) || (fil_rdata >= MAX_SLOTS)) begin
               rsp_status_in = STS_OVF;
            end else begin
               slot_we       = 1'b1;
               slot_waddr    = SAW'(fil_rdata);
               slot_wdata    = DW'(pc_ff);
               fil_we        = 1'b1;
               fil_waddr     = id_addr;
               fil_wdata     = fil_rdata + SW'(1);
               pc_in         = pc_ff + SW'(1);
               rsp_answer_in = ANS_W'(fil_rdata);
            end
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_RD_SLOT: begin
            rsp_valid_in  = 1'b1;
            rsp_answer_in = ANS_W'(slot_rdata);
            state_in      = S_IDLE;
         end
         S_RD_OFF: begin
            rsp_valid_in  = 1'b1;
            rsp_answer_in = ANS_W'(off_rdata);
            state_in      = S_IDLE;
         end
         S_BK_CHK: begin
            // The block exists only if it ends inside the padded total.
            if ((prod_ff + PROD_W'(lb_ff)) > total_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STS_ARG;
               state_in      = S_IDLE;
            end else begin
               e_in     = '0;
               owner_in = '0;
               state_in = S_BK_RD;
            end
         end
         S_BK_RD: begin
            state_in = S_BK_CMP;
         end
         S_BK_CMP: begin
            if (off_rdata <= prod_ff) begin
               owner_in = e_ff;
            end
            e_in = e_ff + EW'(1);
            if ((e_ff + EW'(1)) == le_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_answer_in = ANS_W'(owner_in);
               state_in      = S_IDLE;
            end else begin
               state_in = S_BK_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ec_ff    <= RST_EXPERT_COUNT;
         cfg_bs_ff    <= RST_BLOCK_SIZE;
         cfg_pad_ff   <= 1'b1;
         state_ff     <= S_IDLE;
         vld_ff       <= '0;
         tc_ff        <= '0;
         pc_ff        <= '0;
         total_ff     <= '0;
         le_ff        <= EW'(1);
         lb_ff        <= RST_BLOCK_SIZE;
         fin_ff       <= 1'b0;
         have_off_ff  <= 1'b0;
         pass_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ec_ff    <= cfg_ec_in;
         cfg_bs_ff    <= cfg_bs_in;
         cfg_pad_ff   <= cfg_pad_in;
         state_ff     <= state_in;
         vld_ff       <= vld_in;
         tc_ff        <= tc_in;
         pc_ff        <= pc_in;
         total_ff     <= total_in;
         le_ff        <= le_in;
         lb_ff        <= lb_in;
         fin_ff       <= fin_in;
         have_off_ff  <= have_off_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      id_ff         <= id_in;
      e_ff          <= e_in;
      acc_ff        <= acc_in;
      s_ff          <= s_in;
      prod_ff       <= prod_in;
      owner_ff      <= owner_in;
      rsp_answer_ff <= rsp_answer_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_answer = rsp_answer_ff;
   assign rsp_status = rsp_status_ff;

   // Per-expert token counts.
   etbas_ram #(.WIDTH(TW), .DEPTH(MAX_EXPERTS)) u_counts (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_addr (cnt_raddr),
      .rd_data (cnt_rdata)
   );

   // Exclusive prefix offsets, one entry past the last expert.
   etbas_ram #(.WIDTH(SW), .DEPTH(MAX_EXPERTS + 1)) u_offsets (
      .clock   (clock),
      .wr_en   (off_we),
      .wr_addr (off_waddr),
      .wr_data (off_wdata),
      .rd_addr (off_raddr),
      .rd_data (off_rdata)
   );

   // Next free slot of each expert during the place pass.
   etbas_ram #(.WIDTH(SW), .DEPTH(MAX_EXPERTS)) u_fill (
      .clock   (clock),
      .wr_en   (fil_we),
      .wr_addr (fil_waddr),
      .wr_data (fil_wdata),
      .rd_addr (fil_raddr),
      .rd_data (fil_rdata)
   );

   // Sorted token indexes.
   etbas_ram #(.WIDTH(DW), .DEPTH(MAX_SLOTS)) u_slots (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_waddr),
      .wr_data (slot_wdata),
      .rd_addr (slot_raddr),
      .rd_data (slot_rdata)
   );

   etbas_round #(.TOKEN_W(TW), .ROUND_W(RW)) u_round (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (bs_used),
      .done     (div_done),
      .rounded  (div_rounded)
   );

endmodule

`default_nettype wire

// File: verif/tb_expert_token_block_align_sort.sv
// Self-checking testbench for expert_token_block_align_sort: count, finalize, place and
// read items, checked against an in-bench model of the padded counting sort.
// Depends on etbas_pkg and the block under test.
`timescale 1ns / 1ps

module tb_expert_token_block_align_sort;
   import etbas_pkg::*;

   // Operation codes that the block must reject.
   localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
   localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;
   localparam int ITEM_TARGET = 1350;
   localparam int STALL_LIMIT = 100000;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic [OP_W-1:0] req_operation;
   logic [ID_W-1:0] req_expert_id;
   logic [INDEX_W-1:0] req_index;
   logic rsp_valid;
   logic [ANS_W-1:0] rsp_answer;
   logic [STAT_W-1:0] rsp_status;
   logic csr_write;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0] csr_data;

   expert_token_block_align_sort DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_expert_id(req_expert_id), .req_index(req_index),
      .rsp_valid(rsp_valid), .rsp_answer(rsp_answer), .rsp_status(rsp_status),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   typedef struct {
      logic [OP_W-1:0] op;
      logic [ID_W-1:0] id;
      logic [INDEX_W-1:0] idx;
      int gap;
   } sort_item_type;

   typedef struct {
      logic [ANS_W-1:0] answer;
      logic [STAT_W-1:0] status;
   } sort_result_type;

   sort_item_type pending_items[$];
   sort_result_type expected_results[$];

   int items_queued = 0;
   int items_taken = 0;
   int error_count = 0;
   int stall_cycles = 0;
   int gap_count = 0;
   bit taken_last_edge = 0;
   bit no_idle = 0;

   // Model state of the sorter.
   int unsigned cfg_experts = 256, cfg_block = 64, cfg_pad = 1;
   int unsigned hist[256];
   int unsigned offsets[257];
   int unsigned fill_ptr[256];
   int unsigned slots[16384];
   bit slot_written[16384];
   int unsigned tokens = 0, placed = 0, total = 0;
   int unsigned lat_experts = 1, lat_block = 64;
   bit finalized = 0;

   function automatic int unsigned experts_in_use();
      if (cfg_experts < 1) return 1;
      if (cfg_experts > 256) return 256;
      return cfg_experts;
   endfunction

   function automatic int unsigned block_in_use();
      if (cfg_block < 1) return 1;
      if (cfg_block > 256) return 256;
      return cfg_block;
   endfunction

   // Applies one item to the model and returns the result it must produce.
   function automatic sort_result_type sort_predict(sort_item_type it);
      sort_result_type r;
      int unsigned ec, bs, sum, start_slot, owner;
      r.answer = '0;
      r.status = STS_OK;
      ec = experts_in_use();
      bs = block_in_use();
      case (it.op)
         OP_COUNT: begin
            // A count after finalize opens a new batch.
            if (finalized) begin
               foreach (hist[e]) hist[e] = 0;
               tokens = 0;
               placed = 0;
               finalized = 0;
            end
            if (it.id >= ec) r.status = STS_ARG;
            else if (tokens >= DEF_MAX_TOKENS) r.status = STS_OVF;
            else begin
               hist[it.id]++;
               tokens++;
            end
         end
         OP_FINALIZE: begin
            sum = 0;
            for (int e = 0; e < ec; e++) sum += (hist[e] + bs - 1) / bs * bs;
            if (sum > DEF_MAX_SLOTS) r.status = STS_OVF;
            else begin
               sum = 0;
               for (int e = 0; e < ec; e++) begin
                  offsets[e] = sum;
                  fill_ptr[e] = sum;
                  sum += (hist[e] + bs - 1) / bs * bs;
               end
               offsets[ec] = sum;
               total = sum;
               if (cfg_pad != 0)
                  for (int s = 0; s < total; s++) begin
                     slots[s] = tokens;
                     slot_written[s] = 1;
                  end
               lat_experts = ec;
               lat_block = bs;
               placed = 0;
               finalized = 1;
               r.answer = total;
            end
         end
         OP_PLACE: begin
            if (!finalized || it.id >= ec || it.id >= lat_experts) r.status = STS_ARG;
            else if (fill_ptr[it.id] >= offsets[it.id + 1] || fill_ptr[it.id] >= DEF_MAX_SLOTS)
               r.status = STS_OVF;
            else begin
               slots[fill_ptr[it.id]] = placed;
               slot_written[fill_ptr[it.id]] = 1;
               r.answer = fill_ptr[it.id];
               fill_ptr[it.id]++;
               placed++;
            end
         end
         OP_READ_SLOT: begin
            if (it.idx >= total) r.status = STS_ARG;
            else r.answer = slots[it.idx];
         end
         OP_READ_BLOCK: begin
            if (it.idx >= total / lat_block) r.status = STS_ARG;
            else begin
               start_slot = it.idx * lat_block;
               owner = 0;
               for (int e = 0; e < lat_experts; e++)
                  if (offsets[e] <= start_slot) owner = e;
               r.answer = owner;
            end
         end
         OP_READ_OFFSET: begin
            if (it.idx > lat_experts) r.status = STS_ARG;
            else r.answer = offsets[it.idx];
         end
         default: r.status = STS_ARG;
      endcase
      return r;
   endfunction

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // Driver: a new item goes out only once the previous one was taken and its gap is spent.
   always @(negedge clock) begin
      if (reset) begin
         start <= 0;
      end else if (!start || taken_last_edge) begin
         if (pending_items.size() == 0) begin
            start <= 0;
         end else if (gap_count < pending_items[0].gap) begin
            gap_count++;
            start <= 0;
         end else begin
            req_operation <= pending_items[0].op;
            req_expert_id <= pending_items[0].id;
            req_index <= pending_items[0].idx;
            void'(pending_items.pop_front());
            gap_count = 0;
            start <= 1;
         end
      end
   end

   // Monitor: predicts on every accepted item and checks each strobed result.
   always @(posedge clock) begin
      sort_item_type it;
      sort_result_type want;
      taken_last_edge = 0;
      if (!reset) begin
         stall_cycles++;
         if (start && !busy) begin
            it.op = req_operation;
            it.id = req_expert_id;
            it.idx = req_index;
            it.gap = 0;
            expected_results.push_back(sort_predict(it));
            items_taken++;
            taken_last_edge = 1;
            stall_cycles = 0;
         end
         if (rsp_valid) begin
            stall_cycles = 0;
            if (expected_results.size() == 0) begin
               $error("result with no item outstanding: answer %0d status %0d",
                      rsp_answer, rsp_status);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_answer !== want.answer) begin
                  $error("answer mismatch: expected %0d actual %0d", want.answer, rsp_answer);
                  error_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status mismatch: expected %0d actual %0d", want.status, rsp_status);
                  error_count++;
               end
            end
         end
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   task automatic queue_item(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                             logic [INDEX_W-1:0] idx);
      sort_item_type it;
      it.op = op;
      it.id = id;
      it.idx = idx;
      it.gap = no_idle ? 0 : $urandom_range(0, 10);
      pending_items.push_back(it);
      items_queued++;
   endtask

   // Waits until every queued item has been taken and answered, then lets the block settle.
   task automatic wait_idle();
      do begin
         @(posedge clock);
         #1;
      end while (items_taken != items_queued || expected_results.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= value;
      @(negedge clock);
      csr_write <= 0;
      case (idx)
         CSR_EXPERT_COUNT: cfg_experts = value;
         CSR_BLOCK_SIZE: cfg_block = value;
         CSR_PAD_ENABLE: cfg_pad = value[0];
         default: ;
      endcase
   endtask

   // Slot reads must never land on a slot inside the total that holds nothing yet.
   task automatic queue_read(logic [OP_W-1:0] op, logic [INDEX_W-1:0] idx);
      int tries;
      tries = 0;
      if (op == OP_READ_SLOT)
         while (idx < total && !slot_written[idx]) begin
            tries++;
            if (tries > 40) begin
               if (total >= DEF_MAX_SLOTS) return;
               idx = total;
            end else begin
               idx = $urandom_range(0, total - 1);
            end
         end
      queue_item(op, 0, idx);
   endtask

   initial begin
      int unsigned ec, n, pick;
      logic [ID_W-1:0] ids[$];
      logic [ID_W-1:0] one_id;
      reset = 1;
      start = 0;
      req_operation = '0;
      req_expert_id = '0;
      req_index = '0;
      csr_write = 0;
      csr_index = '0;
      csr_data = '0;
      repeat (6) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // Directed: reads and place before anything was finalized, unknown operations,
      // a count for the highest expert id and a short batch under the reset configuration.
      queue_item(OP_READ_SLOT, 0, 0);
      queue_item(OP_READ_BLOCK, 0, 0);
      queue_item(OP_READ_OFFSET, 0, 1);
      queue_item(OP_READ_OFFSET, 0, 2);
      queue_item(OP_PLACE, 0, 0);
      queue_item(OP_UNUSED_6, 8'hFF, 14'h3FFF);
      queue_item(OP_UNUSED_7, 0, 0);
      queue_item(OP_COUNT, 8'd255, 0);
      queue_item(OP_COUNT, 0, 0);
      queue_item(OP_COUNT, 0, 0);
      queue_item(OP_COUNT, 3, 0);
      queue_item(OP_FINALIZE, 0, 0);
      queue_item(OP_PLACE, 0, 0);
      queue_item(OP_PLACE, 3, 0);
      queue_item(OP_PLACE, 0, 0);
      wait_idle();
      queue_read(OP_READ_SLOT, 1);
      queue_read(OP_READ_SLOT, 64);
      queue_read(OP_READ_SLOT, 14'h3FFF);
      queue_item(OP_READ_BLOCK, 0, 1);
      queue_item(OP_READ_BLOCK, 0, 14'h3FFF);
      queue_item(OP_READ_OFFSET, 0, 256);
      queue_item(OP_READ_OFFSET, 0, 257);
      wait_idle();

      // Slot overflow: 65 experts each rounded up to 256 slots exceed the store.
      write_reg(CSR_EXPERT_COUNT, 9'd65);
      write_reg(CSR_BLOCK_SIZE, 9'd256);
      no_idle = 1;
      for (int e = 0; e < 65; e++) queue_item(OP_COUNT, e, 0);
      queue_item(OP_FINALIZE, 0, 0);
      queue_item(OP_PLACE, 0, 0);
      wait_idle();

      // After the failed finalize the counts stay: expert 0 gets a second token, so each place fits.
      write_reg(CSR_EXPERT_COUNT, 9'd2);
      write_reg(CSR_BLOCK_SIZE, 9'd1);
      write_reg(CSR_PAD_ENABLE, 9'd0);
      queue_item(OP_COUNT, 0, 0);
      queue_item(OP_FINALIZE, 0, 0);
      queue_item(OP_PLACE, 0, 0);
      queue_item(OP_PLACE, 0, 0);
      queue_item(OP_PLACE, 1, 0);
      wait_idle();

      // Too many tokens: a count stream past the token limit, with clamped registers.
      write_reg(CSR_EXPERT_COUNT, 9'd0);
      write_reg(CSR_BLOCK_SIZE, 9'd0);
      for (int t = 0; t < DEF_MAX_TOKENS + 4; t++) queue_item(OP_COUNT, 0, 0);
      queue_item(OP_FINALIZE, 0, 0);
      for (int t = 0; t < 10; t++) queue_item(OP_PLACE, 0, 0);
      wait_idle();
      queue_read(OP_READ_SLOT, 5);
      queue_item(OP_READ_BLOCK, 0, 4095);
      queue_item(OP_READ_BLOCK, 0, 4096);
      wait_idle();

      // Random batches: mostly count, finalize, place of the same ids, then reads.
      while (items_queued < ITEM_TARGET + DEF_MAX_TOKENS + 100) begin
         no_idle = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 3) != 0) begin
            pick = $urandom_range(0, 9);
            case (pick)
               0: write_reg(CSR_EXPERT_COUNT, 9'd256);
               1: write_reg(CSR_EXPERT_COUNT, 9'd511);
               2: write_reg(CSR_EXPERT_COUNT, $urandom);
               default: write_reg(CSR_EXPERT_COUNT, $urandom_range(1, 16));
            endcase
         end
         if ($urandom_range(0, 3) != 0) begin
            pick = $urandom_range(0, 9);
            case (pick)
               0: write_reg(CSR_BLOCK_SIZE, 9'd256);
               1: write_reg(CSR_BLOCK_SIZE, 9'd511);
               2: write_reg(CSR_BLOCK_SIZE, 9'd1);
               3: write_reg(CSR_BLOCK_SIZE, 9'd0);
               default: write_reg(CSR_BLOCK_SIZE, $urandom_range(1, 16));
            endcase
         end
         if ($urandom_range(0, 2) == 0) write_reg(CSR_PAD_ENABLE, $urandom);
         ec = experts_in_use();
         n = $urandom_range(1, 40);
         ids.delete();
         for (int t = 0; t < n; t++) begin
            one_id = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, ec - 1);
            ids.push_back(one_id);
            queue_item(OP_COUNT, one_id, $urandom);
         end
         if ($urandom_range(0, 7) != 0) queue_item(OP_FINALIZE, $urandom, $urandom);
         foreach (ids[t]) begin
            if ($urandom_range(0, 9) != 0) queue_item(OP_PLACE, ids[t], $urandom);
            if ($urandom_range(0, 19) == 0) queue_item(OP_PLACE, $urandom, $urandom);
         end
         wait_idle();
         // A register change here shows that reads keep the values latched at finalize.
         if ($urandom_range(0, 1) == 0) write_reg(CSR_EXPERT_COUNT, $urandom_range(1, 16));
         if ($urandom_range(0, 1) == 0) write_reg(CSR_BLOCK_SIZE, $urandom_range(1, 16));
         for (int r = 0; r < 12; r++) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) queue_item(OP_UNUSED_6, $urandom, $urandom);
            else if (pick == 1) queue_item(OP_UNUSED_7, $urandom, $urandom);
            else if (pick < 8)
               queue_read(OP_READ_SLOT, ($urandom_range(0, 1) != 0) ?
                          $urandom_range(0, total) : $urandom);
            else if (pick < 14)
               queue_read(OP_READ_BLOCK, ($urandom_range(0, 1) != 0) ?
                          $urandom_range(0, total / lat_block) : $urandom);
            else
               queue_read(OP_READ_OFFSET, ($urandom_range(0, 1) != 0) ?
                          $urandom_range(0, lat_experts + 1) : $urandom);
         end
         wait_idle();
      end

      repeat (20) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
